/* src/lshs_pkg.sv */
// Shared types and constants for the limit switch homing sequencer.
// Holds the request and response beat structs, opcode, direction and register codes.
// No dependencies.
package lshs_pkg;

   localparam int LEVEL_BITS_DEF = 16;
   localparam int TIMER_BITS_DEF = 20;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DUTY_BITS      = 10;
   localparam int TICK_BITS      = 10;
   localparam int WEIGHT_BITS    = 16;
   localparam int DUR_BITS       = 16;

   localparam logic [DUTY_BITS-1:0] DUTY_MAX = 10'd1000;

   localparam int CMD_L = 0;
   localparam int CMD_R = 1;
   localparam int CMD_C = 2;
   localparam int CMD_O = 3;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_LEFT   = 3'd1,
      OP_RIGHT  = 3'd2,
      OP_CENTER = 3'd3,
      OP_OFFSET = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      DIR_STOP  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } dir_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEFT_WEIGHT  = 3'd0,
      CSR_RIGHT_WEIGHT = 3'd1,
      CSR_THRESHOLD    = 3'd2,
      CSR_CORNER_DUTY  = 3'd3,
      CSR_CENTER_DUTY  = 3'd4,
      CSR_CENTER_TIME  = 3'd5,
      CSR_OFFSET_TIME  = 3'd6,
      CSR_TICK_MS      = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       left_switch;
      logic       right_switch;
      logic       abort;
   } req_type;

   typedef struct packed {
      logic [1:0]           direction;
      logic [DUTY_BITS-1:0] duty_permille;
      logic                 left_pressed;
      logic                 right_pressed;
      logic                 at_left;
      logic                 at_right;
      logic                 at_center;
      logic                 at_offset;
      logic                 ready_res;
   } rsp_type;

   function automatic logic [DUTY_BITS-1:0] sat_duty(input logic [DUTY_BITS-1:0] d);
      return (d > DUTY_MAX) ? DUTY_MAX : d;
   endfunction

endpackage

/* src/lshs_filter.sv */
// First-order low-pass filter and press detector for one limit switch.
// Uses lshs_pkg for the weight width.
module lshs_filter #(
   parameter int LEVEL_BITS = lshs_pkg::LEVEL_BITS_DEF
) (
   input  logic [LEVEL_BITS-1:0]              level,
   input  logic [lshs_pkg::WEIGHT_BITS-1:0]   weight,
   input  logic [lshs_pkg::WEIGHT_BITS-1:0]   threshold,
   input  logic                               sample,
   input  logic                               update,
   output logic [LEVEL_BITS-1:0]              level_out,
   output logic                               pressed
);
   import lshs_pkg::*;

   localparam int SUM_BITS = LEVEL_BITS + WEIGHT_BITS + 2;

   logic [WEIGHT_BITS:0]            weight_c;
   logic [LEVEL_BITS+WEIGHT_BITS:0] keep_term;
   logic [SUM_BITS-1:0]             new_term;
   logic [SUM_BITS-1:0]             sum;
   logic [LEVEL_BITS-1:0]           filtered;

   always_comb begin
      weight_c  = (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - {1'b0, weight};
      keep_term = weight_c * level;
      if (sample) begin
         new_term = {2'b00, weight, {LEVEL_BITS{1'b0}}} - SUM_BITS'(weight);
      end else begin
         new_term = '0;
      end
      sum       = SUM_BITS'(keep_term) + new_term + SUM_BITS'(1 << (WEIGHT_BITS - 1));
      filtered  = sum[LEVEL_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
      level_out = update ? filtered : level;
      pressed   = {level_out, {WEIGHT_BITS{1'b0}}} > {threshold, {LEVEL_BITS{1'b0}}};
   end

endmodule

/* src/limit_switch_homing_sequencer_top.sv */
// Top level of the limit switch homing sequencer: handshakes, settings registers,
// sequencing state and the response register. Depends on lshs_pkg and lshs_filter.
//
// The block takes one beat per clock cycle and returns exactly one response beat for
// each, in the cycle after acceptance, from a response register. The request side is
// stalled only while that register holds a beat that the receiver is stalling, so the
// sustained rate is one beat per cycle while the receiver does not stall; the path per
// beat is one switch filter multiply, its threshold compare and the sequencing logic.
module limit_switch_homing_sequencer_top #(
   parameter int LEVEL_BITS = lshs_pkg::LEVEL_BITS_DEF,
   parameter int TIMER_BITS = lshs_pkg::TIMER_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lshs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lshs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [lshs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lshs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lshs_pkg::*;

   logic [WEIGHT_BITS-1:0] left_weight_ff, right_weight_ff, threshold_ff;
   logic [DUTY_BITS-1:0]   corner_duty_ff, center_duty_ff;
   logic [DUR_BITS-1:0]    center_time_ff, offset_time_ff;
   logic [TICK_BITS-1:0]   tick_ms_ff;

   logic [LEVEL_BITS-1:0] left_level_ff, right_level_ff;
   logic [LEVEL_BITS-1:0] left_level_in, right_level_in;
   logic [3:0]            pend_ff, pend_in;
   logic [3:0]            flags_ff, flags_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic                  running_ff, running_in;
   dir_type               dir_ff, dir_in;
   logic [DUTY_BITS-1:0]  duty_ff, duty_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  is_tick;
   logic                  left_pressed, right_pressed;
   logic                  ready;
   logic [TIMER_BITS:0]   timer_sum;
   logic [DUR_BITS-1:0]   leg_dur;
   logic [1:0]            leg_bit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign is_tick   = (req_data.opcode == OP_TICK);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lshs_filter #(.LEVEL_BITS(LEVEL_BITS)) u_left_filter (
      .level     (left_level_ff),
      .weight    (left_weight_ff),
      .threshold (threshold_ff),
      .sample    (req_data.left_switch),
      .update    (is_tick),
      .level_out (left_level_in),
      .pressed   (left_pressed)
   );

   lshs_filter #(.LEVEL_BITS(LEVEL_BITS)) u_right_filter (
      .level     (right_level_ff),
      .weight    (right_weight_ff),
      .threshold (threshold_ff),
      .sample    (req_data.right_switch),
      .update    (is_tick),
      .level_out (right_level_in),
      .pressed   (right_pressed)
   );

   always_comb begin
      pend_in    = pend_ff;
      flags_in   = flags_ff;
      elapsed_in = elapsed_ff;
      running_in = running_ff;
      dir_in     = dir_ff;
      duty_in    = duty_ff;
      ready      = 1'b0;
      timer_sum  = '0;
      leg_dur    = '0;
      leg_bit    = 2'(CMD_C);
      case (req_data.opcode)
         OP_TICK: begin
            if (running_in) begin
               timer_sum  = {1'b0, elapsed_in} + (TIMER_BITS+1)'(tick_ms_ff);
               elapsed_in = timer_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}}
                                                  : timer_sum[TIMER_BITS-1:0];
            end
            if (req_data.abort) begin
               dir_in     = DIR_STOP;
               pend_in    = '0;
               flags_in   = '0;
               elapsed_in = '0;
               running_in = 1'b0;
            end
            if (left_pressed && !flags_in[CMD_L] && pend_in[CMD_L]) begin
               flags_in[CMD_L] = 1'b1;
               flags_in[CMD_R] = 1'b0;
               pend_in[CMD_L]  = 1'b0;
               dir_in          = DIR_STOP;
            end
            if (right_pressed && !flags_in[CMD_R] && pend_in[CMD_R]) begin
               flags_in[CMD_R] = 1'b1;
               flags_in[CMD_L] = 1'b0;
               pend_in[CMD_R]  = 1'b0;
               dir_in          = DIR_STOP;
               if (!pend_in[CMD_C] && !pend_in[CMD_O]) begin
                  ready = 1'b1;
               end
            end
            for (int k = 0; k < 2; k++) begin
               leg_bit = (k == 0) ? 2'(CMD_C) : 2'(CMD_O);
               leg_dur = (k == 0) ? center_time_ff : offset_time_ff;
               if (pend_in[leg_bit]) begin
                  if (flags_in[CMD_R]) begin
                     duty_in         = sat_duty(center_duty_ff);
                     dir_in          = DIR_LEFT;
                     elapsed_in      = '0;
                     running_in      = 1'b1;
                     pend_in[CMD_R]  = 1'b0;
                     flags_in[CMD_R] = 1'b0;
                  end
                  if (!pend_in[CMD_R] && !flags_in[CMD_R]
                      && elapsed_in > TIMER_BITS'(leg_dur)) begin
                     elapsed_in        = '0;
                     running_in        = 1'b0;
                     dir_in            = DIR_STOP;
                     flags_in[leg_bit] = 1'b1;
                     pend_in[leg_bit]  = 1'b0;
                     ready             = 1'b1;
                  end
               end
            end
         end
         OP_LEFT, OP_RIGHT, OP_CENTER, OP_OFFSET: begin
            flags_in = '0;
            duty_in  = sat_duty(corner_duty_ff);
            if (req_data.opcode != OP_RIGHT) begin
               elapsed_in = '0;
               running_in = 1'b0;
            end
            pend_in = '0;
            if (req_data.opcode == OP_LEFT) begin
               pend_in[CMD_L] = 1'b1;
               dir_in         = DIR_LEFT;
            end else begin
               pend_in[CMD_R] = 1'b1;
               pend_in[CMD_C] = (req_data.opcode == OP_CENTER);
               pend_in[CMD_O] = (req_data.opcode == OP_OFFSET);
               dir_in         = DIR_RIGHT;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.direction     = dir_in;
      rsp_data_in.duty_permille = duty_in;
      rsp_data_in.left_pressed  = left_pressed;
      rsp_data_in.right_pressed = right_pressed;
      rsp_data_in.at_left       = flags_in[CMD_L];
      rsp_data_in.at_right      = flags_in[CMD_R];
      rsp_data_in.at_center     = flags_in[CMD_C];
      rsp_data_in.at_offset     = flags_in[CMD_O];
      rsp_data_in.ready_res     = ready;
      rsp_valid_in              = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_weight_ff  <= 16'd49152;
         right_weight_ff <= 16'd49152;
         threshold_ff    <= 16'd58982;
         corner_duty_ff  <= 10'd400;
         center_duty_ff  <= 10'd500;
         center_time_ff  <= 16'd8500;
         offset_time_ff  <= 16'd3000;
         tick_ms_ff      <= 10'd50;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LEFT_WEIGHT:  left_weight_ff  <= csr_wdata;
            CSR_RIGHT_WEIGHT: right_weight_ff <= csr_wdata;
            CSR_THRESHOLD:    threshold_ff    <= csr_wdata;
            CSR_CORNER_DUTY:  corner_duty_ff  <= csr_wdata[DUTY_BITS-1:0];
            CSR_CENTER_DUTY:  center_duty_ff  <= csr_wdata[DUTY_BITS-1:0];
            CSR_CENTER_TIME:  center_time_ff  <= csr_wdata;
            CSR_OFFSET_TIME:  offset_time_ff  <= csr_wdata;
            CSR_TICK_MS:      tick_ms_ff      <= csr_wdata[TICK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_level_ff  <= '0;
         right_level_ff <= '0;
         pend_ff        <= '0;
         flags_ff       <= '0;
         elapsed_ff     <= '0;
         running_ff     <= 1'b0;
         dir_ff         <= DIR_STOP;
         duty_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            left_level_ff  <= left_level_in;
            right_level_ff <= right_level_in;
            pend_ff        <= pend_in;
            flags_ff       <= flags_in;
            elapsed_ff     <= elapsed_in;
            running_ff     <= running_in;
            dir_ff         <= dir_in;
            duty_ff        <= duty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_ready_has_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.ready_res |->
         (rsp_data_ff.at_right || rsp_data_ff.at_center || rsp_data_ff.at_offset))
      else $error("Ready pulse without a matching alignment flag.");

   a_ends_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(flags_ff[CMD_L] && flags_ff[CMD_R]))
      else $error("Left and right alignment flags set together.");

   a_timer_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (elapsed_ff == '0))
      else $error("Timer holds a value while stopped.");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("Accepted beat produced no response.");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= DUTY_MAX)
      else $error("Drive duty above full scale.");

endmodule
